/* hw/rtl/radix_prefixed_integer_parser_assert.svh */
// assertion macros for the radix-prefixed integer parser checker
// no dependencies; included by files that carry concurrent assertions
`ifndef RADIX_PREFIXED_INTEGER_PARSER_ASSERT_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RPIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpip assertion failed");

// next-cycle implication, disabled during reset
`define RPIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpip assertion failed");

`endif

/* hw/rtl/rpip_pkg.sv */
// shared types and constants for the radix-prefixed integer parser
// no dependencies; imported by every module of the block
package rpip_pkg;

    localparam int CHAR_W = 8;
    localparam int DIGIT_W = 4;
    localparam int MAG_W = 63;
    localparam int VAL_W = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOWER_O = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic signed [VAL_W-1:0] VAL_MAX_POS = {1'b0, MAG_MAX};
    localparam logic signed [VAL_W-1:0] VAL_MAX_NEG = -VAL_MAX_POS;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_BIN = 2'd2,
        BASE_OCT = 2'd3
    } t_base;

    // one classified character request
    typedef struct packed {
        logic               cmd;
        logic               empty;
        logic               fin;
        logic               minus;
        logic               zero;
        logic               prefix;
        t_base              pfx_base;
        logic               digit_ok;
        logic [DIGIT_W-1:0] digit;
    } t_item;

endpackage

/* hw/rtl/rpip_front.sv */
// front end: accepts input requests and classifies each character
// depends on rpip_pkg
module rpip_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [rpip_pkg::CHAR_W-1:0] i_character,
    input  logic                        i_is_empty,
    input  logic                        i_last,
    input  logic                        i_full,
    output logic                        o_push,
    output rpip_pkg::t_item             o_item
);
    import rpip_pkg::*;

    logic [CHAR_W-1:0] w_off;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_off  = '0;
        o_item = '0;
        o_item.cmd    = i_command;
        o_item.empty  = i_is_empty;
        o_item.fin    = i_last || i_is_empty;
        o_item.minus  = (i_character == CH_MINUS);
        o_item.zero   = (i_character == CH_ZERO);
        o_item.prefix = (i_character == CH_LOWER_X) || (i_character == CH_LOWER_B) ||
                        (i_character == CH_LOWER_O);
        priority if (i_character == CH_LOWER_X) begin
            o_item.pfx_base = BASE_HEX;
        end else if (i_character == CH_LOWER_B) begin
            o_item.pfx_base = BASE_BIN;
        end else if (i_character == CH_LOWER_O) begin
            o_item.pfx_base = BASE_OCT;
        end else begin
            o_item.pfx_base = BASE_DEC;
        end
        // digit value 0..15 regardless of base; base check is done in the back end
        priority if (i_character >= CH_ZERO && i_character <= CH_NINE) begin
            w_off = i_character - CH_ZERO;
            o_item.digit_ok = 1'b1;
        end else if (i_character >= CH_LOWER_A && i_character <= CH_LOWER_F) begin
            w_off = i_character - CH_LOWER_A + CHAR_W'(10);
            o_item.digit_ok = 1'b1;
        end else if (i_character >= CH_UPPER_A && i_character <= CH_UPPER_F) begin
            w_off = i_character - CH_UPPER_A + CHAR_W'(10);
            o_item.digit_ok = 1'b1;
        end else begin
            o_item.digit_ok = 1'b0;
        end
        o_item.digit = w_off[DIGIT_W-1:0];
    end

endmodule

/* hw/rtl/rpip_queue.sv */
// short request queue between the front and back ends
// depends on rpip_pkg
module rpip_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpip_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output rpip_pkg::t_item o_item,
    input  logic            i_pop
);
    import rpip_pkg::*;

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hw/rtl/rpip_back.sv */
// back end: parse state machine, digit accumulator and result register
// depends on rpip_pkg
module rpip_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  rpip_pkg::t_item                   i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rpip_pkg::VAL_W-1:0] o_value,
    output logic                              o_valid_res,
    output logic                              o_overflow
);
    import rpip_pkg::*;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_ZEROS  = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_BAD    = 5'b10000
    } t_phase;

    localparam int SUM_W = MAG_W + 5;

    t_phase           r_phase;
    t_phase           n_phase;
    t_base            r_base;
    t_base            n_base;
    logic             r_neg;
    logic             n_neg;
    logic [MAG_W-1:0] r_acc;
    logic [MAG_W-1:0] n_acc;
    logic             r_sat;
    logic             n_sat;

    logic             r_out_valid;
    logic [MAG_W-1:0] r_out_mag;
    logic             r_out_neg;
    logic             r_out_ok;
    logic             r_out_sat;

    t_base            w_acc_base;
    logic [SUM_W-1:0] w_acc_x;
    logic [SUM_W-1:0] w_dig_x;
    logic [SUM_W-1:0] w_sum;
    logic             w_over;
    logic             w_dig_ok;
    logic             w_do_lead;
    logic             w_do_acc;
    logic             w_ok;
    logic             w_slot_free;
    logic [VAL_W-1:0] w_mag64;

    // digits before the prefix decision are always decimal
    assign w_acc_base = (r_phase == PH_DIGITS) ? r_base : BASE_DEC;
    assign w_acc_x    = SUM_W'(r_acc);
    assign w_dig_x    = SUM_W'(i_item.digit);

    always_comb begin
        unique case (w_acc_base)
            BASE_DEC: w_sum = (w_acc_x << 3) + (w_acc_x << 1) + w_dig_x;
            BASE_HEX: w_sum = (w_acc_x << 4) + w_dig_x;
            BASE_BIN: w_sum = (w_acc_x << 1) + w_dig_x;
            BASE_OCT: w_sum = (w_acc_x << 3) + w_dig_x;
            default:  w_sum = w_acc_x;
        endcase
    end

    assign w_over = |w_sum[SUM_W-1:MAG_W];

    always_comb begin
        unique case (w_acc_base)
            BASE_DEC: w_dig_ok = i_item.digit_ok && (i_item.digit <= DIGIT_W'(9));
            BASE_HEX: w_dig_ok = i_item.digit_ok;
            BASE_BIN: w_dig_ok = i_item.digit_ok && (i_item.digit <= DIGIT_W'(1));
            BASE_OCT: w_dig_ok = i_item.digit_ok && (i_item.digit <= DIGIT_W'(7));
            default:  w_dig_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_base    = r_base;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_sat     = r_sat;
        w_do_lead = 1'b0;
        w_do_acc  = 1'b0;
        if (!i_item.empty) begin
            unique case (r_phase)
                PH_START: begin
                    // signed mode is taken from the first character's command
                    if (i_item.cmd && i_item.minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else begin
                        w_do_lead = 1'b1;
                    end
                end
                PH_SIGN, PH_ZEROS: w_do_lead = 1'b1;
                PH_DIGITS:         w_do_acc  = 1'b1;
                PH_BAD:            ;
                default:           ;
            endcase
            if (w_do_lead) begin
                priority if (i_item.zero) begin
                    n_phase = PH_ZEROS;
                end else if (i_item.prefix) begin
                    // prefix letter needs at least one leading zero
                    if (r_phase == PH_ZEROS) begin
                        n_base  = i_item.pfx_base;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end else begin
                    n_base   = BASE_DEC;
                    n_phase  = PH_DIGITS;
                    w_do_acc = 1'b1;
                end
            end
            if (w_do_acc) begin
                if (!w_dig_ok) begin
                    n_phase = PH_BAD;
                end else if (!r_sat) begin
                    if (w_over) begin
                        n_acc = MAG_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = w_sum[MAG_W-1:0];
                    end
                end
            end
        end
    end

    assign w_ok        = (n_phase == PH_ZEROS) || (n_phase == PH_DIGITS);
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = i_q_valid && (!i_item.fin || w_slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_base      <= BASE_DEC;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.fin) begin
                    r_phase <= PH_START;
                    r_base  <= BASE_DEC;
                    r_neg   <= 1'b0;
                    r_acc   <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_base  <= n_base;
                    r_neg   <= n_neg;
                    r_acc   <= n_acc;
                    r_sat   <= n_sat;
                end
            end
            if (o_pop && i_item.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.fin) begin
            r_out_mag <= w_ok ? n_acc : '0;
            r_out_neg <= w_ok && n_neg;
            r_out_ok  <= w_ok;
            r_out_sat <= w_ok && n_sat;
        end
    end

    assign w_mag64     = {1'b0, r_out_mag};
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_neg ? (VAL_W'(0) - w_mag64) : w_mag64;
    assign o_valid_res = r_out_ok;
    assign o_overflow  = r_out_sat;

endmodule

/* hw/rtl/radix_prefixed_integer_parser.sv */
// Radix-prefixed ASCII integer parser, one character per input request.
// Input channel: i_valid/o_ready with i_command, i_character, i_is_empty, i_last.
// i_command selects signed parsing (one leading minus) and is sampled on the
// first character of a string. A leading zero followed by x, b or o selects
// base 16, 2 or 8; otherwise digits are decimal. An empty request at the start
// of a string gives an invalid result; inside a string it ends the string.
// Output channel: o_valid/i_ready with o_value, o_valid_res, o_overflow; one
// result per string, on its last request. Invalid strings give value 0.
// Magnitudes saturate at 2^63-1 with o_overflow set.
// Throughput: one character per cycle while o_ready is high, set by the
// combinational shift-add accumulator in the back end. A final character is
// written into the queue, then into the result register, and then shows on o_valid.
// A two-entry request queue lets the front keep accepting while a result
// waits on i_ready; once the queue fills, o_ready drops until the receiver
// takes the result. Reset (synchronous, active low) clears the queue, the
// parse state and the result valid flag.
// Depends on rpip_pkg, rpip_front, rpip_queue and rpip_back.
module radix_prefixed_integer_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic [rpip_pkg::CHAR_W-1:0]       i_character,
    input  logic                              i_is_empty,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rpip_pkg::VAL_W-1:0] o_value,
    output logic                              o_valid_res,
    output logic                              o_overflow
);
    import rpip_pkg::*;

    logic  w_full;
    logic  w_push;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_push_item;
    t_item w_head_item;

    rpip_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_character (i_character),
        .i_is_empty  (i_is_empty),
        .i_last      (i_last),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    rpip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_head_item),
        .i_pop   (w_pop)
    );

    rpip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_valid_res (o_valid_res),
        .o_overflow  (o_overflow)
    );

endmodule

/* hw/rtl/rpip_checker.sv */
// port-level checker for the radix-prefixed integer parser, bound to the top
// depends on rpip_pkg and radix_prefixed_integer_parser_assert.svh
`include "radix_prefixed_integer_parser_assert.svh"

module rpip_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              i_command,
    input logic [rpip_pkg::CHAR_W-1:0]       i_character,
    input logic                              i_is_empty,
    input logic                              i_last,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [rpip_pkg::VAL_W-1:0] o_value,
    input logic                              o_valid_res,
    input logic                              o_overflow
);
    import rpip_pkg::*;

    // a stalled result stays offered
    `RPIP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // a stalled result keeps its payload
    `RPIP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_value) && $stable(o_valid_res) && $stable(o_overflow))

    // malformed strings read as zero with no overflow
    `RPIP_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_valid && !o_valid_res, (o_value == '0) && !o_overflow)

    // saturated results sit at the largest magnitude
    `RPIP_ASSERT_IMP(a_sat_value, i_clk, i_rst_n, o_valid && o_overflow, o_valid_res && ((o_value == VAL_MAX_POS) || (o_value == VAL_MAX_NEG)))

endmodule

bind radix_prefixed_integer_parser rpip_checker u_rpip_checker (.*);

/* bench/radix_prefixed_integer_parser_checker.sv */
`timescale 1ns / 100ps
// result checker for the radix-prefixed integer parser: follows each accepted
// character request, works out the parsed value and compares results in order
// depends on rpip_pkg
module radix_prefixed_integer_parser_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic                              i_command,
    input  logic [rpip_pkg::CHAR_W-1:0]       i_character,
    input  logic                              i_is_empty,
    input  logic                              i_last,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic signed [rpip_pkg::VAL_W-1:0] i_value,
    input  logic                              i_valid_res,
    input  logic                              i_overflow,
    output int                                o_mismatches,
    output int                                o_results_due
);
    import rpip_pkg::*;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SIGN,
        SCAN_ZEROS,
        SCAN_DIGITS,
        SCAN_BAD
    } t_scan;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             valid_res;
        logic             overflow;
    } t_parsed;

    localparam logic [VAL_W-1:0] MAG_LIMIT = {1'b0, MAG_MAX};

    t_scan            scan_state = SCAN_START;
    t_base            radix_sel  = BASE_DEC;
    logic             zero_seen  = 1'b0;
    logic             negative   = 1'b0;
    logic             signed_str = 1'b0;
    logic [VAL_W-1:0] magnitude  = '0;
    logic             clipped    = 1'b0;

    t_parsed parsed_due[$];
    int      mismatches = 0;

    function automatic void clear_scan();
        scan_state = SCAN_START;
        radix_sel  = BASE_DEC;
        zero_seen  = 1'b0;
        negative   = 1'b0;
        signed_str = 1'b0;
        magnitude  = '0;
        clipped    = 1'b0;
    endfunction

    // -1 when c is no digit of base b
    function automatic int digit_value(input logic [CHAR_W-1:0] c, input t_base b);
        int d;
        d = -1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = int'(c) - int'(CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = int'(c) - int'(CH_LOWER_A) + 10;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = int'(c) - int'(CH_UPPER_A) + 10;
        end
        if (d >= 0) begin
            case (b)
                BASE_HEX: ;
                BASE_BIN: if (d >= 2) d = -1;
                BASE_OCT: if (d >= 8) d = -1;
                default:  if (d >= 10) d = -1;
            endcase
        end
        return d;
    endfunction

    function automatic void fold_digit(input logic [CHAR_W-1:0] c);
        int d;
        logic [VAL_W-1:0] r;
        d = digit_value(c, radix_sel);
        case (radix_sel)
            BASE_HEX: r = 16;
            BASE_BIN: r = 2;
            BASE_OCT: r = 8;
            default:  r = 10;
        endcase
        if (d < 0) begin
            scan_state = SCAN_BAD;
        end else if (!clipped) begin
            // magnitude sticks at the limit once it would pass it
            if (magnitude > (MAG_LIMIT - VAL_W'(d)) / r) begin
                magnitude = MAG_LIMIT;
                clipped   = 1'b1;
            end else begin
                magnitude = magnitude * r + VAL_W'(d);
            end
        end
    endfunction

    function automatic void lead_char(input logic [CHAR_W-1:0] c);
        if (c == CH_ZERO) begin
            zero_seen  = 1'b1;
            scan_state = SCAN_ZEROS;
        end else if (c == CH_LOWER_X || c == CH_LOWER_B || c == CH_LOWER_O) begin
            if (!zero_seen) begin
                scan_state = SCAN_BAD;
            end else begin
                radix_sel  = (c == CH_LOWER_X) ? BASE_HEX :
                             (c == CH_LOWER_B) ? BASE_BIN : BASE_OCT;
                scan_state = SCAN_DIGITS;
            end
        end else begin
            radix_sel  = BASE_DEC;
            scan_state = SCAN_DIGITS;
            fold_digit(c);
        end
    endfunction

    function automatic void parse_request(input logic cmd, input logic [CHAR_W-1:0] ch,
                                          input logic empty, input logic fin);
        t_parsed res;
        logic    ok;
        if (scan_state == SCAN_START && !empty) signed_str = cmd;
        if (empty) begin
            fin = 1'b1;
        end else begin
            case (scan_state)
                SCAN_START: begin
                    if (signed_str && ch == CH_MINUS) begin
                        negative   = 1'b1;
                        scan_state = SCAN_SIGN;
                    end else begin
                        lead_char(ch);
                    end
                end
                SCAN_SIGN, SCAN_ZEROS: lead_char(ch);
                SCAN_DIGITS:           fold_digit(ch);
                default: ;
            endcase
        end
        if (fin) begin
            ok            = (scan_state == SCAN_ZEROS || scan_state == SCAN_DIGITS);
            res.value     = ok ? (negative ? -magnitude : magnitude) : '0;
            res.valid_res = ok;
            res.overflow  = ok && clipped;
            parsed_due.push_back(res);
            clear_scan();
        end
    endfunction

    always @(posedge i_clk) begin
        t_parsed want;
        if (!i_rst_n) begin
            clear_scan();
            parsed_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (parsed_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %h/%b/%b",
                             $time, i_value, i_valid_res, i_overflow);
                end else begin
                    want = parsed_due.pop_front();
                    if (i_value !== want.value) begin
                        mismatches++;
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, want.value, i_value);
                    end
                    if (i_valid_res !== want.valid_res) begin
                        mismatches++;
                        $display("%0t: valid_res mismatch: expected %b, actual %b",
                                 $time, want.valid_res, i_valid_res);
                    end
                    if (i_overflow !== want.overflow) begin
                        mismatches++;
                        $display("%0t: overflow mismatch: expected %b, actual %b",
                                 $time, want.overflow, i_overflow);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                parse_request(i_command, i_character, i_is_empty, i_last);
        end
        o_mismatches  <= mismatches;
        o_results_due <= parsed_due.size();
    end

endmodule

/* bench/radix_prefixed_integer_parser_tb.sv */
`timescale 1ns / 100ps
// top of the radix-prefixed integer parser bench: clock, reset, character
// requests and receiver stalls; checking is done in the checker module
// depends on rpip_pkg, radix_prefixed_integer_parser and its checker
module radix_prefixed_integer_parser_tb;
    import rpip_pkg::*;

    localparam int ITEM_GOAL    = 1050;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_command = 1'b0;
    logic [CHAR_W-1:0] i_character = '0;
    logic i_is_empty = 1'b0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [VAL_W-1:0] o_value;
    logic o_valid_res;
    logic o_overflow;

    int mismatches;
    int results_due;

    int items_sent = 0;
    int burst_left = 0;
    logic gaps_on = 1'b0;
    int hold_req = 0;
    logic [CHAR_W-1:0] str_chars[$];

    radix_prefixed_integer_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_character (i_character),
        .i_is_empty  (i_is_empty),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_valid_res (o_valid_res),
        .o_overflow  (o_overflow)
    );

    radix_prefixed_integer_parser_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_command     (i_command),
        .i_character   (i_character),
        .i_is_empty    (i_is_empty),
        .i_last        (i_last),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_value       (o_value),
        .i_valid_res   (o_valid_res),
        .i_overflow    (o_overflow),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("FAIL radix_prefixed_integer_parser");
        $finish;
    end

    // one request, held until accepted; bursts end in a random gap
    task automatic offer(input logic cmd, input logic [CHAR_W-1:0] ch,
                         input logic empty, input logic fin);
        int gap;
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_character <= ch;
        i_is_empty  <= empty;
        i_last      <= fin;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(0, 10);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // command only counts on the first character, so later ones get noise
    task automatic send_string(input logic cmd, input logic end_empty);
        int n;
        n = str_chars.size();
        if (n == 0) begin
            offer(cmd, CHAR_W'($urandom_range(0, 255)), 1'b1,
                  logic'($urandom_range(0, 1)));
        end else begin
            for (int i = 0; i < n; i++)
                offer((i == 0) ? cmd : logic'($urandom_range(0, 1)), str_chars[i], 1'b0,
                      (i == n - 1) && !end_empty);
            if (end_empty)
                offer(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)), 1'b1,
                      logic'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_text(input logic cmd, input string s, input logic end_empty);
        str_chars.delete();
        for (int i = 0; i < s.len(); i++) str_chars.push_back(s[i]);
        send_string(cmd, end_empty);
    endtask

    task automatic drain_results();
        if (i_valid) i_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int d);
        if (d < 10) return CHAR_W'(int'(CH_ZERO) + d);
        return CHAR_W'(int'($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + d - 10);
    endfunction

    // well formed number text: optional minus, leading zeros, prefix, digits
    task automatic build_number_text(input logic sgn);
        t_base b;
        int zeros;
        int mode;
        int d;
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] r;
        logic [CHAR_W-1:0] digits[$];
        str_chars.delete();
        if (sgn && $urandom_range(0, 1)) str_chars.push_back(CH_MINUS);
        b = t_base'($urandom_range(0, 3));
        if (b == BASE_DEC) zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        else zeros = $urandom_range(1, 3);
        repeat (zeros) str_chars.push_back(CH_ZERO);
        case (b)
            BASE_HEX: begin str_chars.push_back(CH_LOWER_X); r = 16; end
            BASE_BIN: begin str_chars.push_back(CH_LOWER_B); r = 2; end
            BASE_OCT: begin str_chars.push_back(CH_LOWER_O); r = 8; end
            default:  r = 10;
        endcase
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            // prefix or zeros with no digits after them
            if (b == BASE_DEC && zeros == 0) str_chars.push_back(CH_ZERO);
        end else begin
            if (mode < 3) mag = VAL_W'($urandom_range(0, 999));
            else if (mode < 6) mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            else if (mode < 8)
                mag = {1'b0, MAG_MAX} - VAL_W'(2) + VAL_W'($urandom_range(0, 4));
            else mag = {$urandom, $urandom} | {1'b1, {(VAL_W-1){1'b0}}};
            do begin
                d = int'(mag % r);
                digits.push_front(digit_char(d));
                mag = mag / r;
            end while (mag != 0);
            // saturated magnitudes must ignore any further digits
            if (mode >= 8)
                repeat ($urandom_range(0, 3))
                    digits.push_back(digit_char($urandom_range(0, int'(r) - 1)));
            foreach (digits[k]) str_chars.push_back(digits[k]);
        end
    endtask

    // receiver: random stall pattern, plus long hold-offs on request
    initial begin
        int hold_seen;
        int mode_left;
        int cadence;
        t_rx_mode rx_mode;
        hold_seen = 0;
        mode_left = 0;
        cadence   = 0;
        rx_mode   = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                cadence++;
                case (rx_mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= logic'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (cadence % 5) < 3;
                endcase
            end
        end
    end

    initial begin
        int n_str;
        int kind;
        int pos;
        logic cmd;
        logic end_empty;
        logic saved_gaps;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings, sent back to back
        offer(1'b1, 8'hA5, 1'b1, 1'b0);   // empty request at string start
        send_text(1'b0, "0", 1'b0);
        send_text(1'b1, "-", 1'b1);       // lone minus, closed by an empty request
        send_text(1'b1, "-00", 1'b0);
        send_text(1'b0, "0o7", 1'b0);
        send_text(1'b1, "0b", 1'b0);
        send_text(1'b0, "x1", 1'b0);
        send_text(1'b1, "-9", 1'b0);
        send_text(1'b0, "-1", 1'b0);
        send_text(1'b1, "1-", 1'b0);
        send_text(1'b0, "7z5", 1'b0);
        str_chars = '{8'h00, 8'hFF};
        send_string(1'b1, 1'b0);

        gaps_on = 1'b1;
        n_str = 0;
        while (items_sent < ITEM_GOAL) begin
            n_str++;
            if (n_str % 30 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (n_str % 70 == 40) drain_results();
            if (n_str % 50 == 25) begin
                // receiver holds off while single digit strings pile up
                hold_req <= hold_req + 1;
                saved_gaps = gaps_on;
                gaps_on = 1'b0;
                repeat (6) begin
                    str_chars.delete();
                    str_chars.push_back(CHAR_W'(int'(CH_ZERO) + $urandom_range(0, 9)));
                    send_string(logic'($urandom_range(0, 1)), 1'b0);
                end
                gaps_on = saved_gaps;
            end

            kind = $urandom_range(0, 19);
            cmd = logic'($urandom_range(0, 1));
            end_empty = 1'b0;
            if (kind < 12) begin
                build_number_text(cmd);
            end else if (kind == 12) begin
                build_number_text(cmd);
                end_empty = 1'b1;
            end else if (kind < 16) begin
                build_number_text(cmd);
                pos = $urandom_range(0, str_chars.size() - 1);
                case ($urandom_range(0, 3))
                    0: str_chars[pos] = CHAR_W'($urandom_range(0, 255));
                    1: str_chars[pos] = CH_MINUS;
                    2: str_chars[pos] = CH_LOWER_X;
                    default: str_chars[pos] = CH_UPPER_F;
                endcase
            end else if (kind < 18) begin
                str_chars.delete();
                repeat ($urandom_range(1, 8))
                    str_chars.push_back(CHAR_W'($urandom_range(0, 255)));
            end else if (kind == 18) begin
                str_chars.delete();
            end else begin
                // signed text parsed in unsigned mode
                build_number_text(1'b1);
                cmd = 1'b0;
            end
            send_string(cmd, end_empty);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("PASS radix_prefixed_integer_parser");
        end else begin
            $display("FAIL radix_prefixed_integer_parser");
        end
        $finish;
    end

endmodule
